// ===== src/stmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stmc_pkg;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 31;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_load;
    logic take_query;
    logic take_clear;
    logic take_other;
    logic search_first;
    logic search_step;
    logic out_load;
  } stmc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;
  } stmc_stat_t;

endpackage

`default_nettype wire

// ===== src/stmc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stmc_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/stmc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stmc_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [stmc_pkg::CMD_W-1:0]  in_command,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output stmc_pkg::stmc_cmd_t              cmd,
  input  wire stmc_pkg::stmc_stat_t        stat
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FIRST  = 2'd1;
  localparam logic [1:0] S_STEP   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    cmd.take_load  = accept && (in_command == stmc_pkg::CMD_LOAD);
    cmd.take_query = accept && (in_command == stmc_pkg::CMD_QUERY);
    cmd.take_clear = accept && (in_command == stmc_pkg::CMD_CLEAR);
    cmd.take_other = accept && !cmd.take_load && !cmd.take_query && !cmd.take_clear;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = cmd.take_query ? S_FIRST : S_FINISH;
        end
      end
      S_FIRST: begin
        cmd.search_first = 1'b1;
        state_nxt = stat.search_done ? S_FINISH : S_STEP;
      end
      S_STEP: begin
        cmd.search_step = 1'b1;
        if (stat.search_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A search step only follows the first probe or another step.
  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> ($past(state_r) == S_FIRST || $past(state_r) == S_STEP))
    else $error("search step entered out of order");

  // The result register is only overwritten once its beat has left.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> slot_free)
    else $error("result loaded over a pending beat");

  // Anything but a query goes straight to the result stage.
  a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cmd.take_query) |=> (state_r == S_FINISH))
    else $error("non-query command did not finish directly");

endmodule

`default_nettype wire

// ===== src/stmc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stmc_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [stmc_pkg::VALUE_W-1:0]  in_value,
  input  wire stmc_pkg::stmc_cmd_t           cmd,
  output stmc_pkg::stmc_stat_t               stat,
  output logic                               out_found,
  output logic [stmc_pkg::POS_W-1:0]         out_position,
  output logic [stmc_pkg::COUNT_W-1:0]       out_match_count,
  output logic                               out_status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  logic [CW-1:0]                 count_r;
  logic [stmc_pkg::COUNT_W-1:0]  hit_r;
  logic [stmc_pkg::VALUE_W-1:0]  key_r;
  logic [CW-1:0]                 lo_r, hi_r;
  logic [AW-1:0]                 mid_r;
  logic                          found_r, status_r;
  logic [AW-1:0]                 pos_r;

  logic [CW-1:0]                 nlo, nhi, diff, mid;
  logic                          empty, eq, gt, searching;
  logic [stmc_pkg::VALUE_W-1:0]  rd_data;
  logic                          wr_en;
  logic [AW+stmc_pkg::POS_W-1:0] pos_ext;

  assign wr_en     = cmd.take_load && (count_r < FULL);
  assign searching = cmd.search_first || cmd.search_step;
  assign eq        = (rd_data == key_r);
  assign gt        = (rd_data > key_r);

  // Narrow the range after a probe, then pick the next midpoint.
  always_comb begin
    nlo = lo_r;
    nhi = hi_r;
    if (cmd.search_step) begin
      if (gt) begin
        nhi = CW'(mid_r);
      end else begin
        nlo = CW'(mid_r) + CW'(1);
      end
    end
    empty = (nlo >= nhi);
    diff  = nhi - nlo - CW'(1);
    mid   = nlo + (diff >> 1);
  end

  assign stat.search_done = (cmd.search_step && eq) || empty;

  stmc_ram #(
    .WIDTH (stmc_pkg::VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata (in_value),
    .re    (searching),
    .raddr (mid[AW-1:0]),
    .rdata (rd_data)
  );

  assign pos_ext = {{stmc_pkg::POS_W{1'b0}}, pos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      hit_r    <= '0;
      lo_r     <= '0;
      hi_r     <= '0;
      found_r  <= 1'b0;
      status_r <= 1'b0;
    end else begin
      if (cmd.take_load || cmd.take_query || cmd.take_clear || cmd.take_other) begin
        found_r  <= 1'b0;
        status_r <= 1'b0;
      end
      if (cmd.take_load) begin
        if (wr_en) begin
          count_r <= count_r + CW'(1);
        end else begin
          status_r <= 1'b1;
        end
      end
      if (cmd.take_clear) begin
        count_r <= '0;
        hit_r   <= '0;
      end
      if (cmd.take_query) begin
        lo_r <= '0;
        hi_r <= count_r;
      end
      if (searching) begin
        lo_r <= nlo;
        hi_r <= nhi;
      end
      if (cmd.search_step && eq) begin
        found_r <= 1'b1;
        if (hit_r != '1) begin
          hit_r <= hit_r + stmc_pkg::COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_query) begin
      key_r <= in_value;
    end
    if (cmd.take_load || cmd.take_query || cmd.take_clear || cmd.take_other) begin
      pos_r <= '0;
    end
    if (searching) begin
      mid_r <= mid[AW-1:0];
    end
    if (cmd.search_step && eq) begin
      pos_r <= mid_r;
    end
    if (cmd.out_load) begin
      out_found       <= found_r;
      out_position    <= pos_ext[stmc_pkg::POS_W-1:0];
      out_match_count <= hit_r;
      out_status      <= status_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("entry count beyond table depth");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= hi_r)
    else $error("search range inverted");

  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (hit_r != '0))
    else $error("hit flagged without a counted hit");

endmodule

`default_nettype wire

// ===== src/sorted_table_match_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted table match counter. Load beats (command 0) append a value to a table of
// TABLE_DEPTH entries that is expected to be loaded in ascending order; a load into a
// full table is refused and returns status 1. Query beats (command 1) binary-search the
// loaded entries and return found, the zero-based match position (low 10 bits) and the
// saturating 16-bit hit counter, which counts up on each hit. Clear beats (command 2)
// empty the table and zero the counter; command 3 changes nothing. Every input beat
// gives exactly one result beat. Load, clear and no-op beats skip the search and go straight
// to the result stage. A query runs a search loop that issues one read of the table memory
// (one write port, one read port) per cycle and compares the returned entry in the next.
// The input is taken only while no item is in work, but a new beat is accepted while the
// previous result still waits on the output. If the table is not sorted, the search still
// runs the same probe sequence and reports whatever it finds.
module sorted_table_match_counter #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [stmc_pkg::CMD_W-1:0]    in_command,
  input  wire logic [stmc_pkg::VALUE_W-1:0]  in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic [stmc_pkg::POS_W-1:0]         out_position,
  output logic [stmc_pkg::COUNT_W-1:0]       out_match_count,
  output logic                               out_status
);

  stmc_pkg::stmc_cmd_t  cmd;
  stmc_pkg::stmc_stat_t stat;

  // The controller sequences each beat; the datapath holds the table, counters and
  // the search registers.
  stmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  stmc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_match_count (out_match_count),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

// ===== dv/sorted_table_match_counter_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sorted table match counter. A shadow copy of the table,
// the entry count and the hit counter predicts every result beat; the directed rows at
// the start carry typed-in results where they are obvious. The random part loads mostly
// ascending tables of random content, queries them with hits, near misses and extremes,
// and mixes in free-form noise. A short tail queries a one-entry table and looks at the
// counter with a no-op.
module sorted_table_match_counter_tb;

  localparam int CMD_W   = stmc_pkg::CMD_W;
  localparam int VALUE_W = stmc_pkg::VALUE_W;
  localparam int POS_W   = stmc_pkg::POS_W;
  localparam int COUNT_W = stmc_pkg::COUNT_W;
  localparam logic [CMD_W-1:0] CMD_LOAD  = stmc_pkg::CMD_LOAD;
  localparam logic [CMD_W-1:0] CMD_QUERY = stmc_pkg::CMD_QUERY;
  localparam logic [CMD_W-1:0] CMD_CLEAR = stmc_pkg::CMD_CLEAR;

  localparam int          DEPTH       = 1024;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam longint      CYCLE_LIMIT = 64'd200_000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          MAX_REPORTS  = 25;
  localparam logic [VALUE_W-1:0] VALUE_TOP = {VALUE_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

  // One result beat, field by field.
  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] match_count;
    logic               status;
  } match_result_t;

  // One row of the directed table. When typed is set, res is the result to expect;
  // otherwise the shadow model supplies it.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic               typed;
    match_result_t      res;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [CMD_W-1:0]   in_command;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic               out_found;
  logic [POS_W-1:0]   out_position;
  logic [COUNT_W-1:0] out_match_count;
  logic               out_status;

  // Shadow state of the block.
  logic [VALUE_W-1:0] shadow_table [DEPTH];
  int unsigned        shadow_count;
  logic [COUNT_W-1:0] shadow_hits;

  match_result_t pending_results [$];

  // Knobs for the two sides. The receiver also obeys hold_off, which a separate
  // process raises for a long stretch to back the block up.
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 50;
  logic        hold_off;

  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  longint      cycle_count;

  // Tallies for the closing summary.
  int unsigned n_loads, n_refused, n_queries, n_hits, n_clears, n_noops;
  int unsigned peak_count;
  logic [COUNT_W-1:0] peak_hits;

  // Directed rows. The first queries run on an empty table right after reset; the
  // table then gets a duplicate and both value extremes; later an out-of-order load
  // shows that the search runs on unchanged over an unsorted table.
  localparam int N_DIRECTED = 23;
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_QUERY, 31'd0,          1'b1, '{1'b0, 10'd0, 16'd0, 1'b0}},
    '{CMD_QUERY, VALUE_TOP,      1'b1, '{1'b0, 10'd0, 16'd0, 1'b0}},
    '{CMD_NOP,   VALUE_TOP,      1'b1, '{1'b0, 10'd0, 16'd0, 1'b0}},
    '{CMD_LOAD,  31'd0,          1'b1, '{1'b0, 10'd0, 16'd0, 1'b0}},
    '{CMD_QUERY, 31'd0,          1'b1, '{1'b1, 10'd0, 16'd1, 1'b0}},
    '{CMD_LOAD,  31'd5,          1'b0, '0},
    '{CMD_LOAD,  31'd5,          1'b0, '0},
    '{CMD_LOAD,  31'd1000,       1'b0, '0},
    '{CMD_LOAD,  VALUE_TOP - 1,  1'b0, '0},
    '{CMD_LOAD,  VALUE_TOP,      1'b1, '{1'b0, 10'd0, 16'd1, 1'b0}},
    '{CMD_QUERY, VALUE_TOP,      1'b0, '0},
    '{CMD_QUERY, 31'd5,          1'b0, '0},
    '{CMD_QUERY, 31'd3,          1'b0, '0},
    '{CMD_QUERY, VALUE_TOP - 1,  1'b0, '0},
    '{CMD_NOP,   31'd0,          1'b0, '0},
    '{CMD_LOAD,  31'd1,          1'b0, '0},
    '{CMD_QUERY, 31'd1,          1'b0, '0},
    '{CMD_QUERY, 31'h2AAAAAAA,   1'b0, '0},
    '{CMD_CLEAR, VALUE_TOP,      1'b1, '{1'b0, 10'd0, 16'd0, 1'b0}},
    '{CMD_QUERY, 31'd5,          1'b1, '{1'b0, 10'd0, 16'd0, 1'b0}},
    '{CMD_LOAD,  31'h55555555,   1'b1, '{1'b0, 10'd0, 16'd0, 1'b0}},
    '{CMD_QUERY, 31'h55555555,   1'b1, '{1'b1, 10'd0, 16'd1, 1'b0}},
    '{CMD_CLEAR, 31'd0,          1'b1, '{1'b0, 10'd0, 16'd0, 1'b0}}
  };

  sorted_table_match_counter #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_position   (out_position),
    .out_match_count(out_match_count),
    .out_status     (out_status)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one beat to the shadow state and returns the result the block must give.
  // The search probes the midpoint of the remaining range, taking the lower middle,
  // and stops at the first probe that matches; this is what makes duplicate and
  // unsorted tables predictable.
  function automatic match_result_t table_next_result(input logic [CMD_W-1:0] cmd,
                                                      input logic [VALUE_W-1:0] val);
    match_result_t r;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   mid;
    r = '0;
    case (cmd)
      CMD_LOAD: begin
        n_loads++;
        if (shadow_count >= DEPTH) begin
          r.status = 1'b1;
          n_refused++;
        end else begin
          shadow_table[shadow_count] = val;
          shadow_count++;
          if (shadow_count > peak_count) peak_count = shadow_count;
        end
      end
      CMD_QUERY: begin
        n_queries++;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
          mid = lo + (hi - 1 - lo) / 2;
          if (shadow_table[mid] == val) begin
            r.found    = 1'b1;
            r.position = mid[POS_W-1:0];
            break;
          end
          if (shadow_table[mid] > val) hi = mid;
          else lo = mid + 1;
        end
        if (r.found) begin
          n_hits++;
          // The counter sticks at its top value.
          if (shadow_hits != COUNT_TOP) shadow_hits++;
          if (shadow_hits > peak_hits) peak_hits = shadow_hits;
        end
      end
      CMD_CLEAR: begin
        n_clears++;
        shadow_count = 0;
        shadow_hits  = '0;
      end
      default: n_noops++;
    endcase
    r.match_count = shadow_hits;
    return r;
  endfunction

  // Offers one beat and returns at the edge where it is taken. The valid line is
  // only lowered when a gap is inserted, so back-to-back beats keep it high and a
  // single nonblocking write per edge drives it.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                           input logic typed = 1'b0, input match_result_t typed_res = '0);
    match_result_t r;
    r = table_next_result(cmd, val);
    if (typed) r = typed_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(r);
    beats_sent++;
  endtask

  // A value that is loaded in the shadow table, or any value when it is empty.
  function automatic logic [VALUE_W-1:0] loaded_value();
    if (shadow_count == 0) return VALUE_W'($urandom);
    return shadow_table[$urandom_range(shadow_count - 1)];
  endfunction

  // Random stimulus. Most of it is built from well-formed runs: an optional clear,
  // an ascending load of random content (with an occasional duplicate), then a burst
  // of queries. The rest is free-form noise over all four commands.
  task automatic run_random(input int unsigned n_beats);
    int unsigned stop_at;
    int unsigned k;
    int unsigned nq;
    longint      span;
    longint      v;
    logic [VALUE_W-1:0] q;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(9) < 7) begin
        if (shadow_count > 900 || $urandom_range(1) == 1)
          send_beat(CMD_CLEAR, VALUE_W'($urandom));
        k    = ($urandom_range(7) == 0) ? $urandom_range(200, 33) : $urandom_range(32, 1);
        span = 64'h7FFF_FFFF / (k + 1);
        v    = $urandom_range(32'(span));
        for (int i = 0; i < k; i++) begin
          send_beat(CMD_LOAD, v[VALUE_W-1:0]);
          if ($urandom_range(15) != 0) v += $urandom_range(32'(span), 1);
        end
        nq = $urandom_range(12, 1);
        for (int i = 0; i < nq; i++) begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4: q = loaded_value();
            5:             q = '0;
            6:             q = VALUE_TOP;
            7:             q = loaded_value() + 1'b1;
            default:       q = VALUE_W'($urandom);
          endcase
          send_beat(CMD_QUERY, q);
        end
      end else begin
        repeat ($urandom_range(6, 1)) send_beat(CMD_W'($urandom), VALUE_W'($urandom));
      end
    end
  endtask

  // Compares one field and reports it on a mismatch.
  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Receiver. It stalls at random, or for the whole hold-off stretch.
  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: every beat taken on the output is matched against the oldest
  // prediction still waiting.
  always @(posedge clk) begin
    match_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected, actual %0h %0h %0h %0h", $time,
                   out_found, out_position, out_match_count, out_status);
      end else begin
        want = pending_results.pop_front();
        check_field("found",       want.found,       out_found);
        check_field("position",    want.position,    out_position);
        check_field("match_count", want.match_count, out_match_count);
        check_field("status",      want.status,      out_status);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("sorted_table_match_counter_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_command   = CMD_NOP;
    in_value     = '0;
    out_ready    = 1'b0;
    hold_off     = 1'b0;
    shadow_count = 0;
    shadow_hits  = '0;
    peak_count   = 0;
    peak_hits    = '0;
    beats_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    cycle_count  = 0;
    n_loads = 0; n_refused = 0; n_queries = 0; n_hits = 0; n_clears = 0; n_noops = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows, with the sender idling lightly and the receiver heavily.
    for (int i = 0; i < N_DIRECTED; i++)
      send_beat(directed_rows[i].cmd, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].res);

    run_random(140);

    send_idle_pct = 50;
    recv_idle_pct = 21;
    run_random(140);

    // No idling from here on. The receiver first holds off for a long stretch while
    // the sender keeps offering beats, so the block backs up and stalls its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    run_random(140);

    // Query a one-entry table holding the top value, then look at the counter with
    // a no-op.
    send_beat(CMD_CLEAR, '0);
    send_beat(CMD_LOAD, VALUE_TOP);
    repeat (4) send_beat(CMD_QUERY, VALUE_TOP);
    send_beat(CMD_NOP, VALUE_W'($urandom));
    send_beat(CMD_QUERY, '0);
    send_beat(CMD_CLEAR, VALUE_W'($urandom));

    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;

    $display("Checked %0d result beats: %0d loads (%0d refused), %0d queries (%0d hits),",
             results_seen, n_loads, n_refused, n_queries, n_hits);
    $display("%0d clears, %0d no-ops; table peaked at %0d entries, hit counter at %0d.",
             n_clears, n_noops, peak_count, peak_hits);
    if (mismatches == 0) begin
      $display("sorted_table_match_counter_tb: PASS");
    end else begin
      $display("sorted_table_match_counter_tb: FAIL");
    end
    $finish;
  end

endmodule
